[hdl/acmd_pkg.sv]
package acmd_pkg;

    // Column symbols: 0..4 are bases, 5 and above read as gap
    localparam logic [2:0] SYM_GAP = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_CIGAR = 2'd0;
    localparam logic [1:0] KIND_MD    = 2'd1;
    localparam logic [1:0] KIND_SUM   = 2'd2;

    // CIGAR operation codes on the result channel
    localparam logic [1:0] CIG_M = 2'd0;
    localparam logic [1:0] CIG_I = 2'd1;
    localparam logic [1:0] CIG_D = 2'd2;

    // MD token forms
    localparam logic [1:0] MD_MISMATCH  = 2'd0;
    localparam logic [1:0] MD_DEL_FIRST = 2'd1;
    localparam logic [1:0] MD_DEL_MORE  = 2'd2;
    localparam logic [1:0] MD_FINAL     = 2'd3;

    localparam logic [7:0] READ_LENGTH_RESET = 8'd100;

    // Open run operation
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_M    = 2'd1,
        OP_I    = 2'd2,
        OP_D    = 2'd3
    } op_t;

    // Results caused by one column, as the front classifies them
    typedef struct packed {
        logic       close_v;
        logic [1:0] close_op;
        logic [7:0] close_len;
        logic       md_v;
        logic [1:0] md_form;
        logic [7:0] md_count;
        logic [2:0] md_base;
        logic       fin_v;
        logic       fin_run_v;
        logic [1:0] fin_op;
        logic [7:0] fin_len;
        logic [7:0] fin_count;
        logic [7:0] fin_edits;
        logic [7:0] fin_lead;
    } rec_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] cigar_op;
        logic [7:0] run_length;
        logic [1:0] md_form;
        logic [7:0] md_count;
        logic [2:0] md_base;
        logic [7:0] edit_count;
        logic [7:0] lead_shift;
        logic       last;
    } res_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [1:0] cigar_of(input op_t op);
        logic [1:0] c;
        unique case (op)
            OP_M:    c = CIG_M;
            OP_I:    c = CIG_I;
            OP_D:    c = CIG_D;
            default: c = CIG_M;
        endcase
        return c;
    endfunction

endpackage

[hdl/acmd_if.sv]
interface acmd_col_if;
    logic       valid;
    logic       ready;
    logic [2:0] read_base;
    logic [2:0] ref_base;
    logic       path_end;

    modport source (output valid, read_base, ref_base, path_end, input ready);
    modport sink (input valid, read_base, ref_base, path_end, output ready);
endinterface

interface acmd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] cigar_op;
    logic [7:0] run_length;
    logic [1:0] md_form;
    logic [7:0] md_count;
    logic [2:0] md_base;
    logic [7:0] edit_count;
    logic [7:0] lead_shift;
    logic       last;

    modport source (output valid, kind, cigar_op, run_length, md_form, md_count, md_base,
                    edit_count, lead_shift, last, input ready);
    modport sink (input valid, kind, cigar_op, run_length, md_form, md_count, md_base,
                  edit_count, lead_shift, last, output ready);
endinterface

[hdl/acmd_front.sv]
module acmd_front
    import acmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    acmd_col_if.sink   col,
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_rec
);

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_ENC  = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    logic [7:0] read_length_reg;
    phase_t     phase_reg, phase_next;
    op_t        op_reg, op_next;
    logic [7:0] run_reg, run_next;
    logic [7:0] match_reg, match_next;
    logic       indel_reg, indel_next;
    logic [7:0] bases_reg, bases_next;
    logic [7:0] edits_reg, edits_next;
    logic [7:0] skip_reg, skip_next;

    logic fire;
    logic rg, fg;
    op_t  cls;
    logic fin;
    logic done;
    rec_t rec;

    assign col.ready = !q_full;
    assign fire      = col.valid && col.ready;
    assign rg        = col.read_base >= SYM_GAP;
    assign fg        = col.ref_base >= SYM_GAP;

    // Classify the column
    always_comb
    begin
        priority if (!rg && !fg)
            cls = OP_M;
        else if (!rg)
            cls = OP_I;
        else if (!fg)
            cls = OP_D;
        else
            cls = OP_NONE;
    end

    // Update run state and collect the results of the column
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        run_next   = run_reg;
        match_next = match_reg;
        indel_next = indel_reg;
        bases_next = bases_reg;
        edits_next = edits_reg;
        skip_next  = skip_reg;
        rec        = '0;
        fin        = 1'b0;
        done       = 1'b0;

        if (fire)
        begin
            if (phase_reg == PH_DONE)
            begin
                if (col.path_end)
                    phase_next = PH_LEAD;
            end
            else if (phase_reg == PH_LEAD && rg)
            begin
                skip_next = sat_inc(skip_reg);
                fin       = col.path_end;
            end
            else
            begin
                phase_next = PH_ENC;
                if (cls != OP_NONE)
                begin
                    // close a run on change of operation
                    if (op_reg != OP_NONE && op_reg != cls)
                    begin
                        rec.close_v   = 1'b1;
                        rec.close_op  = cigar_of(op_reg);
                        rec.close_len = run_reg;
                        run_next      = 8'd0;
                    end
                    op_next  = cls;
                    run_next = sat_inc(run_next);

                    if (cls == OP_D)
                    begin
                        edits_next  = sat_inc(edits_reg);
                        rec.md_v    = 1'b1;
                        rec.md_base = col.ref_base;
                        if (indel_reg)
                        begin
                            rec.md_form  = MD_DEL_MORE;
                            rec.md_count = 8'd0;
                        end
                        else
                        begin
                            rec.md_form  = MD_DEL_FIRST;
                            rec.md_count = match_reg;
                        end
                        match_next = 8'd0;
                        indel_next = 1'b1;
                    end
                    else
                    begin
                        if (cls == OP_M)
                        begin
                            if (col.read_base != col.ref_base)
                            begin
                                rec.md_v     = 1'b1;
                                rec.md_form  = MD_MISMATCH;
                                rec.md_count = match_reg;
                                rec.md_base  = col.ref_base;
                                match_next   = 8'd0;
                                edits_next   = sat_inc(edits_reg);
                            end
                            else
                            begin
                                match_next = sat_inc(match_reg);
                            end
                        end
                        else
                        begin
                            edits_next = sat_inc(edits_reg);
                        end
                        indel_next = 1'b0;
                        bases_next = sat_inc(bases_reg);
                        done       = (bases_next == read_length_reg);
                    end
                end
                fin = done || col.path_end;
            end

            // Close the alignment and clear for the next one
            if (fin)
            begin
                rec.fin_v     = 1'b1;
                rec.fin_run_v = (op_next != OP_NONE);
                rec.fin_op    = cigar_of(op_next);
                rec.fin_len   = run_next;
                rec.fin_count = match_next;
                rec.fin_edits = edits_next;
                rec.fin_lead  = skip_next;
                op_next       = OP_NONE;
                run_next      = 8'd0;
                match_next    = 8'd0;
                indel_next    = 1'b0;
                bases_next    = 8'd0;
                edits_next    = 8'd0;
                skip_next     = 8'd0;
                phase_next    = col.path_end ? PH_LEAD : PH_DONE;
            end
        end
    end

    assign q_push = fire && (rec.close_v || rec.md_v || rec.fin_v);
    assign q_rec  = rec;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            read_length_reg <= READ_LENGTH_RESET;
        else if (cfg_wr_en)
            read_length_reg <= cfg_wr_data;
    end

    // Advance alignment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            op_reg    <= OP_NONE;
            run_reg   <= 8'd0;
            match_reg <= 8'd0;
            indel_reg <= 1'b0;
            bases_reg <= 8'd0;
            edits_reg <= 8'd0;
            skip_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            run_reg   <= run_next;
            match_reg <= match_next;
            indel_reg <= indel_next;
            bases_reg <= bases_next;
            edits_reg <= edits_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

[hdl/acmd_fifo.sv]
module acmd_fifo
    import acmd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output rec_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

endmodule

[hdl/acmd_back.sv]
module acmd_back
    import acmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rec_t       head,
    input  logic       empty,
    output logic       pop,
    acmd_res_if.source res
);

    // Slot order: closed run, column MD token, open run, final count, summary
    logic [4:0] served_reg, served_next;
    logic [4:0] mask;
    logic [4:0] rem;
    logic [4:0] sel;
    logic       last_one;
    logic       load;
    res_t       pick;
    res_t       out_reg;
    logic       out_valid_reg, out_valid_next;

    assign mask     = {head.fin_v, head.fin_v, head.fin_v && head.fin_run_v,
                       head.md_v, head.close_v};
    assign rem      = mask & ~served_reg;
    assign sel      = rem & (~rem + 5'd1);
    assign last_one = (rem & ~sel) == 5'd0;
    assign load     = !empty && (!out_valid_reg || res.ready);
    assign pop      = load && last_one;

    // Build the result of the lowest pending slot
    always_comb
    begin
        pick = '0;
        priority if (rem[0])
        begin
            pick.kind       = KIND_CIGAR;
            pick.cigar_op   = head.close_op;
            pick.run_length = head.close_len;
        end
        else if (rem[1])
        begin
            pick.kind     = KIND_MD;
            pick.md_form  = head.md_form;
            pick.md_count = head.md_count;
            pick.md_base  = head.md_base;
        end
        else if (rem[2])
        begin
            pick.kind       = KIND_CIGAR;
            pick.cigar_op   = head.fin_op;
            pick.run_length = head.fin_len;
        end
        else if (rem[3])
        begin
            pick.kind     = KIND_MD;
            pick.md_form  = MD_FINAL;
            pick.md_count = head.fin_count;
        end
        else
        begin
            pick.kind       = KIND_SUM;
            pick.edit_count = head.fin_edits;
            pick.lead_shift = head.fin_lead;
            pick.last       = 1'b1;
        end
    end

    // Track served slots and output valid
    always_comb
    begin
        served_next    = served_reg;
        out_valid_next = out_valid_reg;
        if (res.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            served_next    = pop ? 5'd0 : (served_reg | sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg    <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output transaction
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= pick;
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = out_reg.kind;
    assign res.cigar_op   = out_reg.cigar_op;
    assign res.run_length = out_reg.run_length;
    assign res.md_form    = out_reg.md_form;
    assign res.md_count   = out_reg.md_count;
    assign res.md_base    = out_reg.md_base;
    assign res.edit_count = out_reg.edit_count;
    assign res.lead_shift = out_reg.lead_shift;
    assign res.last       = out_reg.last;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_served_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((served_reg & ~mask) == 5'd0))
        else $error("served slot not present in head entry");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && sel[4]) |=> (res.valid && res.last && res.kind == KIND_SUM))
        else $error("summary not marked last");

    a_served_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (served_reg == 5'd0))
        else $error("served mask not cleared on pop");

endmodule

[hdl/alignment_path_to_cigar_md_top.sv]
// Channel  Role    Transaction
// -------  ------  -----------------------------------------------------------
// col      in      one alignment column: read_base, ref_base, path_end
// res      out     one CIGAR run, MD token or closing summary
// cfg      in      cfg_wr_en / cfg_wr_data write read_length, no read-back
//
// A column is taken every cycle while the result queue has room; the front
// updates all counters in that cycle, and its results pass through the queue
// and then the registered output. Results leave one per cycle while res is ready,
// from a registered output; a column causes zero to five, so the output port sets
// the sustained rate during bursts of closings. Reset clears all counters, the
// queue and the output, and sets read_length to 100. A stalled res side fills the
// QUEUE_DEPTH-entry queue before col stalls.
module alignment_path_to_cigar_md_top
    import acmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    acmd_col_if.sink   col,
    acmd_res_if.source res
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    rec_t q_in;
    rec_t q_head;

    acmd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .col         (col),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (q_in)
    );

    acmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    acmd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .empty (q_empty),
        .pop   (q_pop),
        .res   (res)
    );

endmodule
